FILE: sv/b64sd_pkg.sv
// shared types and codes for the base64 stream decoder
// no dependencies; used by every module of the block
package b64sd_pkg;

	localparam int CharW   = 8;
	localparam int SymW    = 6;
	localparam int CountW  = 3;
	localparam int StatusW = 2;

	// stop status codes
	localparam logic [StatusW-1:0] ST_DECODING = 2'd0;
	localparam logic [StatusW-1:0] ST_PADDED   = 2'd1;
	localparam logic [StatusW-1:0] ST_INVALID  = 2'd2;

	// character codes
	localparam logic [CharW-1:0] CH_LF    = 8'h0A;
	localparam logic [CharW-1:0] CH_CR    = 8'h0D;
	localparam logic [CharW-1:0] CH_SPACE = 8'h20;
	localparam logic [CharW-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CharW-1:0] CH_SLASH = 8'h2F;
	localparam logic [CharW-1:0] CH_DIG0  = 8'h30;
	localparam logic [CharW-1:0] CH_DIG9  = 8'h39;
	localparam logic [CharW-1:0] CH_PAD   = 8'h3D;
	localparam logic [CharW-1:0] CH_UC_A  = 8'h41;
	localparam logic [CharW-1:0] CH_UC_Z  = 8'h5A;
	localparam logic [CharW-1:0] CH_LC_A  = 8'h61;
	localparam logic [CharW-1:0] CH_LC_Z  = 8'h7A;

	typedef struct packed {
		logic [CharW-1:0] char_in;
		logic             msg_start;
	} in_item_t;

	typedef struct packed {
		logic [CharW-1:0]   byte_out;
		logic               byte_valid;
		logic [StatusW-1:0] status;
	} out_item_t;

	// classification of one character
	typedef struct packed {
		logic            is_ws;
		logic            is_pad;
		logic            is_sym;
		logic [SymW-1:0] sym;
	} char_class_t;

endpackage

FILE: sv/b64sd_char_class.sv
// character classifier: whitespace, padding, alphabet symbol value
// depends on b64sd_pkg
module b64sd_char_class (
	input  logic [b64sd_pkg::CharW-1:0] char_in,
	output b64sd_pkg::char_class_t      cls
);

	logic [b64sd_pkg::CharW-1:0] val;

	always_comb begin
		cls = '0;
		val = '0;
		cls.is_ws  = (char_in == b64sd_pkg::CH_LF) || (char_in == b64sd_pkg::CH_CR) ||
		             (char_in == b64sd_pkg::CH_SPACE);
		cls.is_pad = (char_in == b64sd_pkg::CH_PAD);
		if (char_in inside {[b64sd_pkg::CH_UC_A:b64sd_pkg::CH_UC_Z]}) begin
			cls.is_sym = 1'b1;
			val = char_in - b64sd_pkg::CH_UC_A;
		end else if (char_in inside {[b64sd_pkg::CH_LC_A:b64sd_pkg::CH_LC_Z]}) begin
			cls.is_sym = 1'b1;
			val = char_in - b64sd_pkg::CH_LC_A + 8'd26;
		end else if (char_in inside {[b64sd_pkg::CH_DIG0:b64sd_pkg::CH_DIG9]}) begin
			cls.is_sym = 1'b1;
			val = char_in - b64sd_pkg::CH_DIG0 + 8'd52;
		end else if (char_in == b64sd_pkg::CH_PLUS) begin
			cls.is_sym = 1'b1;
			val = 8'd62;
		end else if (char_in == b64sd_pkg::CH_SLASH) begin
			cls.is_sym = 1'b1;
			val = 8'd63;
		end
		cls.sym = val[b64sd_pkg::SymW-1:0];
	end

endmodule

FILE: sv/b64sd_core.sv
// decoder state (residue, bit count, stop status) and per-item update
// depends on b64sd_pkg
module b64sd_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  msg_start,
	input  b64sd_pkg::char_class_t cls,
	output b64sd_pkg::out_item_t  result
);

	logic [b64sd_pkg::SymW-1:0]    residue_q, residue_d, res_eff;
	logic [b64sd_pkg::CountW-1:0]  count_q, count_d, cnt_eff;
	logic [b64sd_pkg::StatusW-1:0] stop_q, stop_d, stop_eff;
	logic [11:0]                   acc;
	logic [3:0]                    cnt_new;
	logic [2:0]                    shamt;
	logic [11:0]                   shifted;
	logic [5:0]                    keep_mask;

	always_comb begin
		// message start clears state before the character is handled
		res_eff   = msg_start ? '0 : residue_q;
		cnt_eff   = msg_start ? '0 : count_q;
		stop_eff  = msg_start ? b64sd_pkg::ST_DECODING : stop_q;
		acc       = {res_eff, cls.sym};
		cnt_new   = {1'b0, cnt_eff} + 4'd6;
		shamt     = 3'(cnt_new - 4'd8);
		shifted   = acc >> shamt;
		keep_mask = 6'((7'd1 << shamt) - 7'd1);
		residue_d = res_eff;
		count_d   = cnt_eff;
		stop_d    = stop_eff;
		result    = '0;
		if (stop_eff == b64sd_pkg::ST_DECODING && !cls.is_ws) begin
			if (cls.is_pad) begin
				stop_d = b64sd_pkg::ST_PADDED;
			end else if (!cls.is_sym) begin
				stop_d = b64sd_pkg::ST_INVALID;
			end else if (cnt_new >= 4'd8) begin
				result.byte_out   = shifted[7:0];
				result.byte_valid = 1'b1;
				residue_d         = acc[5:0] & keep_mask;
				count_d           = shamt;
			end else begin
				residue_d = acc[5:0];
				count_d   = cnt_new[2:0];
			end
		end
		result.status = stop_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			residue_q <= '0;
			count_q   <= '0;
			stop_q    <= b64sd_pkg::ST_DECODING;
		end else if (step) begin
			residue_q <= residue_d;
			count_q   <= count_d;
			stop_q    <= stop_d;
		end
	end

`ifndef SYNTHESIS
	// pending bit count is always even and at most six
	a_count_even: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q[0] == 1'b0) && (count_q <= 3'd6))
		else $error("bit count out of range");

	// once stopped, state holds until a message start
	a_stop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		step && !msg_start && (stop_q != b64sd_pkg::ST_DECODING)
		|=> $stable(stop_q) && $stable(residue_q) && $stable(count_q))
		else $error("state changed after stop");

	// residue bits above the count are zero; checked here for a zero count
	a_residue_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 3'd0) |-> (residue_q == '0))
		else $error("stale residue bits");
`endif

endmodule

FILE: sv/base64_stream_decoder_unit.sv
// an accepted item reaches the output through the input register and then the result register
// throughput: one item per cycle while out_ready stays high; the state update is one short shift-and-mask pass
// the input stage takes one more item while a result waits; with both stages full in_ready
// follows out_ready in the same cycle, so a released stall leaves no bubble
// reset: arst_n asynchronously clears valid flags, residue, bit count and stop status
// depends on b64sd_pkg, b64sd_char_class, b64sd_core
module base64_stream_decoder_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  b64sd_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output b64sd_pkg::out_item_t out_data
);

	// input register stage
	logic                   valid_s1;
	b64sd_pkg::in_item_t    item_s1;
	// result register
	logic                   out_valid_q;
	b64sd_pkg::out_item_t   out_data_q;

	logic                   adv_s1;
	b64sd_pkg::char_class_t cls;
	b64sd_pkg::out_item_t   result;

	// the stage-one item moves on when the result register is free or being drained
	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// classify the registered character
	b64sd_char_class u_class (
		.char_in (item_s1.char_in),
		.cls     (cls)
	);

	// state update, committed only when the item moves to the result register
	b64sd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv_s1),
		.msg_start (item_s1.msg_start),
		.cls       (cls),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	// a decoded byte only comes from a character handled while decoding
	a_byte_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.byte_valid |-> (out_data.status == b64sd_pkg::ST_DECODING))
		else $error("byte delivered with stop status");

	// no byte means a zero byte field
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.byte_valid |-> (out_data.byte_out == '0))
		else $error("byte field not cleared");

	// a held stage-one item is not lost while the output stalls
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(item_s1))
		else $error("stage one item dropped");
`endif

endmodule

FILE: bench/b64sd_checker.sv
`timescale 1ns / 1ps
// result checker for the base64 stream decoder: predicts each item's result and compares
// depends on b64sd_pkg for the item types, status codes and character codes
module b64sd_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  b64sd_pkg::in_item_t  in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  b64sd_pkg::out_item_t out_data,
	output int                   fail_count,
	output int                   pending,
	output int                   results_checked,
	output int                   bytes_checked
);

	localparam logic [6:0] NoSymbol = 7'd64;

	// decoder state as the block should hold it
	logic [b64sd_pkg::SymW-1:0]    residue      = '0;
	logic [b64sd_pkg::CountW-1:0]  pending_bits = '0;
	logic [b64sd_pkg::StatusW-1:0] stop_status  = b64sd_pkg::ST_DECODING;

	// results still owed by the block, oldest first
	b64sd_pkg::out_item_t decoded_q[$];

	function automatic logic [6:0] symbol_value(logic [b64sd_pkg::CharW-1:0] c);
		if (c >= b64sd_pkg::CH_UC_A && c <= b64sd_pkg::CH_UC_Z)
			return 7'(c - b64sd_pkg::CH_UC_A);
		if (c >= b64sd_pkg::CH_LC_A && c <= b64sd_pkg::CH_LC_Z)
			return 7'(c - b64sd_pkg::CH_LC_A + 8'd26);
		if (c >= b64sd_pkg::CH_DIG0 && c <= b64sd_pkg::CH_DIG9)
			return 7'(c - b64sd_pkg::CH_DIG0 + 8'd52);
		if (c == b64sd_pkg::CH_PLUS) return 7'd62;
		if (c == b64sd_pkg::CH_SLASH) return 7'd63;
		return NoSymbol;
	endfunction

	// advances the state by one character and returns what the block must report
	function automatic b64sd_pkg::out_item_t decode_char(b64sd_pkg::in_item_t it);
		logic [6:0]           sym;
		logic [11:0]          acc;
		int                   cnt;
		b64sd_pkg::out_item_t res;
		res = '0;
		if (it.msg_start) begin
			residue      = '0;
			pending_bits = '0;
			stop_status  = b64sd_pkg::ST_DECODING;
		end
		if (stop_status == b64sd_pkg::ST_DECODING && it.char_in != b64sd_pkg::CH_LF &&
				it.char_in != b64sd_pkg::CH_CR && it.char_in != b64sd_pkg::CH_SPACE) begin
			if (it.char_in == b64sd_pkg::CH_PAD) begin
				stop_status = b64sd_pkg::ST_PADDED;
			end else begin
				sym = symbol_value(it.char_in);
				if (sym == NoSymbol) begin
					stop_status = b64sd_pkg::ST_INVALID;
				end else begin
					acc = {residue, sym[b64sd_pkg::SymW-1:0]};
					cnt = int'(pending_bits) + b64sd_pkg::SymW;
					if (cnt >= 8) begin
						cnt = cnt - 8;
						res.byte_out   = 8'(acc >> cnt);
						res.byte_valid = 1'b1;
					end
					residue      = 6'(acc & ((12'd1 << cnt) - 12'd1));
					pending_bits = 3'(cnt);
				end
			end
		end
		res.status = stop_status;
		return res;
	endfunction

	task automatic report_mismatch(string field, int want, int got);
		fail_count++;
		$error("%s mismatch: expected %0h, got %0h", field, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		b64sd_pkg::out_item_t want;
		if (!arst_n) begin
			residue      = '0;
			pending_bits = '0;
			stop_status  = b64sd_pkg::ST_DECODING;
			decoded_q.delete();
		end else begin
			if (in_valid && in_ready)
				decoded_q = {decoded_q, decode_char(in_data)};
			if (out_valid && out_ready) begin
				results_checked++;
				if (decoded_q.size() == 0) begin
					fail_count++;
					$error("result %h arrived with nothing outstanding", out_data);
				end else begin
					want = decoded_q.pop_front();
					if (want.byte_valid)
						bytes_checked++;
					if (out_data.byte_out !== want.byte_out)
						report_mismatch("byte_out", want.byte_out, out_data.byte_out);
					if (out_data.byte_valid !== want.byte_valid)
						report_mismatch("byte_valid", want.byte_valid, out_data.byte_valid);
					if (out_data.status !== want.status)
						report_mismatch("status", want.status, out_data.status);
				end
			end
		end
		pending = decoded_q.size();
	end

endmodule

FILE: bench/tb_base64_stream_decoder_unit.sv
`timescale 1ns / 1ps
// top of the base64 stream decoder bench: clock, reset, character stimulus and verdict
// depends on b64sd_pkg, base64_stream_decoder_unit and b64sd_checker
module tb_base64_stream_decoder_unit;

	localparam int StallLimit = 2000; // cycles with no item moving on either channel
	localparam int HoldCycles = 60;   // long receiver hold-off, well beyond the block's two stages
	localparam int TotalItems = 1225;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	b64sd_pkg::in_item_t  in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	b64sd_pkg::out_item_t out_data;

	int fail_count;
	int pending;
	int results_checked;
	int bytes_checked;

	int items_sent   = 0;
	int n_messages   = 0;
	int stall_count  = 0;
	bit quiet        = 1'b0; // set for the closing stretch: no idling anywhere
	bit hold_request = 1'b0; // asks the receiver for one long hold-off

	always #6 clk = ~clk;

	base64_stream_decoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	b64sd_checker u_checker (.*);

	// maps a six-bit symbol onto its alphabet character
	function automatic logic [b64sd_pkg::CharW-1:0] sym_char(int unsigned s);
		if (s < 26) return b64sd_pkg::CH_UC_A + 8'(s);
		if (s < 52) return b64sd_pkg::CH_LC_A + 8'(s - 26);
		if (s < 62) return b64sd_pkg::CH_DIG0 + 8'(s - 52);
		if (s == 62) return b64sd_pkg::CH_PLUS;
		return b64sd_pkg::CH_SLASH;
	endfunction

	// offers one character and returns at the edge where it is taken;
	// valid stays high from one item to the next unless an idle burst falls in between
	task automatic send_char(input logic [b64sd_pkg::CharW-1:0] c, input logic start);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= b64sd_pkg::in_item_t'{char_in: c, msg_start: start};
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// stops offering and waits for every owed result; status is read on the falling edge
	// so the checker's update at the rising edge has settled
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// receiver: random stalls in short bursts, plain ready stretches, and one long hold-off
	initial begin
		forever begin
			if (hold_request) begin
				// long hold so the block fills up and pushes back on the sender
				out_ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				hold_request = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// watchdog: a stuck handshake on either side ends the run
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
		if (stall_count >= StallLimit) begin
			$display("tb_base64_stream_decoder_unit NOT OK");
			$finish;
		end
	end

	// sender and verdict
	initial begin
		int                          n_sym;
		int                          pads;
		logic                        first;
		logic [b64sd_pkg::CharW-1:0] c;
		bit                          hold_done;
		bit                          pause_done;
		hold_done  = 1'b0;
		pause_done = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		// a clean quantum of four characters gives three bytes, with a newline inside
		send_char("T", 1'b1);
		send_char("W", 1'b0);
		send_char(b64sd_pkg::CH_LF, 1'b0);
		send_char("F", 1'b0);
		send_char("u", 1'b0);
		// top and bottom of each alphabet range, with a space and a carriage return skipped
		send_char("/", 1'b1);
		send_char("+", 1'b0);
		send_char(b64sd_pkg::CH_SPACE, 1'b0);
		send_char("9", 1'b0);
		send_char("0", 1'b0);
		send_char("z", 1'b0);
		send_char("a", 1'b0);
		send_char(b64sd_pkg::CH_CR, 1'b0);
		send_char("Z", 1'b0);
		send_char("A", 1'b0);
		// padding ends the message, the next character is ignored and leftover bits dropped
		send_char("Q", 1'b0);
		send_char(b64sd_pkg::CH_PAD, 1'b0);
		send_char("B", 1'b0);
		// invalid character on the start item itself, then ignored input
		send_char(8'hFF, 1'b1);
		send_char("A", 1'b0);
		// whitespace on a start item, then a zero byte which is invalid
		send_char(b64sd_pkg::CH_SPACE, 1'b1);
		send_char(8'h00, 1'b0);
		// padding as the very first character, then a restart with one symbol followed by an invalid byte
		send_char(b64sd_pkg::CH_PAD, 1'b1);
		send_char("g", 1'b1);
		send_char(8'h80, 1'b0);

		// random part: mostly well-formed messages with random content, some noise
		while (items_sent < TotalItems) begin
			if (!hold_done && items_sent >= 300) begin
				hold_request = 1'b1;
				hold_done    = 1'b1;
			end
			if (!pause_done && items_sent >= 650) begin
				wait_drained();
				pause_done = 1'b1;
			end
			quiet = (items_sent >= 1050);
			n_messages++;
			// now and then a message runs on from the previous state without a start
			first = ($urandom_range(0, 29) != 0);
			if ($urandom_range(0, 9) == 0) begin
				// pure noise: any byte at all
				repeat ($urandom_range(1, 8)) begin
					send_char(8'($urandom_range(0, 255)), first);
					first = 1'b0;
				end
			end else begin
				n_sym = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40)
				                                    : $urandom_range(1, 12);
				repeat (n_sym) begin
					if ($urandom_range(0, 7) == 0) begin
						case ($urandom_range(0, 2))
							0: c = b64sd_pkg::CH_LF;
							1: c = b64sd_pkg::CH_CR;
							default: c = b64sd_pkg::CH_SPACE;
						endcase
						send_char(c, first);
						first = 1'b0;
					end
					c = sym_char($urandom_range(0, 63));
					// a stray byte breaks the message part-way
					if ($urandom_range(0, 59) == 0)
						c = 8'($urandom_range(0, 255));
					// a restart in the middle of a message
					if ($urandom_range(0, 79) == 0)
						first = 1'b1;
					send_char(c, first);
					first = 1'b0;
				end
				pads = $urandom_range(0, 2);
				repeat (pads)
					send_char(b64sd_pkg::CH_PAD, 1'b0);
				// trailing character, ignored if the message has ended
				if ($urandom_range(0, 4) == 0)
					send_char(sym_char($urandom_range(0, 63)), 1'b0);
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		@(negedge clk);
		$display("covered %0d characters in %0d random messages plus the directed set",
			items_sent, n_messages);
		$display("%0d results checked, %0d of them carrying a decoded byte",
			results_checked, bytes_checked);
		if (fail_count == 0 && pending == 0) begin
			$display("tb_base64_stream_decoder_unit OK");
		end else begin
			$display("tb_base64_stream_decoder_unit NOT OK");
		end
		$finish;
	end

endmodule

FILE: base64_stream_decoder_unit.f
sv/b64sd_pkg.sv
sv/b64sd_char_class.sv
sv/b64sd_core.sv
sv/base64_stream_decoder_unit.sv
bench/b64sd_checker.sv
bench/tb_base64_stream_decoder_unit.sv
